FILE: hw/rtl/brti_pkg.sv
// Shared types, constants and the rank compare for the bounded ranked table.
// No dependencies; imported by brti_cell and bounded_ranked_table_insert_core.
`timescale 1ns / 1ps

package brti_pkg;

    // fixed field geometry
    localparam int KEY_FIELDS       = 4;
    localparam int KEY_W            = 32;
    localparam int TAG_W            = 16;
    localparam int CFG_W            = 5;
    localparam int DEFAULT_CAPACITY = 16;

    // keys that may ever take part in a compare
    localparam int NUM_KEYS = 4;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_ENTRIES = 2'd0;
    localparam logic [1:0] CFG_KEYS_IN_USE = 2'd1;
    localparam logic [1:0] CFG_LOW_MASK    = 2'd2;

    // configuration reset values
    localparam logic [4:0] MAX_ENTRIES_RST = 5'd10;
    localparam logic [2:0] KEYS_IN_USE_RST = 3'd1;
    localparam logic [3:0] LOW_MASK_RST    = 4'd0;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_READ   = 2'd3
    } brti_cmd_t;

    typedef struct packed {
        brti_cmd_t          command;
        logic signed [31:0] key_zero;
        logic signed [31:0] key_one;
        logic signed [31:0] key_two;
        logic signed [31:0] key_three;
        logic [15:0]        tag;
        logic [3:0]         read_index;
    } brti_in_t;

    typedef struct packed {
        logic               placed;
        logic [3:0]         position;
        logic [4:0]         entry_count;
        logic               entry_valid;
        logic signed [31:0] entry_key_zero;
        logic signed [31:0] entry_key_one;
        logic signed [31:0] entry_key_two;
        logic signed [31:0] entry_key_three;
        logic [15:0]        entry_tag;
    } brti_out_t;

    // key zero sits at index zero
    typedef logic [KEY_FIELDS-1:0][KEY_W-1:0] brti_keys_t;

    typedef struct packed {
        brti_keys_t       keys;
        logic [TAG_W-1:0] tag;
    } brti_rec_t;

    // control broadcast from the top level to every cell
    typedef struct packed {
        logic                  compare;
        logic                  insert;
        logic [KEY_FIELDS-1:0] key_use;
        logic [KEY_FIELDS-1:0] low_best;
    } brti_ctl_t;

    // gather the four keys of an item
    function automatic brti_keys_t item_keys(brti_in_t item);
        return {item.key_three, item.key_two, item.key_one, item.key_zero};
    endfunction

    // held record ranks strictly better than the probe: first differing key decides
    function automatic logic held_better(brti_keys_t held, brti_keys_t probe,
                                         logic [KEY_FIELDS-1:0] key_use,
                                         logic [KEY_FIELDS-1:0] low_best);
        logic res;
        res = 1'b0;
        for (int i = KEY_FIELDS - 1; i >= 0; i--)
        begin
            if (key_use[i] && (held[i] != probe[i]))
            begin
                if (low_best[i])
                    res = $signed(held[i]) < $signed(probe[i]);
                else
                    res = $signed(held[i]) > $signed(probe[i]);
            end
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/brti_cell.sv
// One slot of the ranked table: holds a record, ranks it against a probe
// and shifts in its neighbor's record on insert. Depends on brti_pkg.
`timescale 1ns / 1ps

module brti_cell
    import brti_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    parameter int INDEX    = 0,
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  logic       clk,
    input  brti_ctl_t  ctl,
    input  logic [CW-1:0] count,
    input  logic [CW-1:0] top,
    input  logic [3:0] read_index,
    input  brti_keys_t probe,
    input  brti_rec_t  fresh,
    input  brti_rec_t  prev_rec,
    input  logic       prev_better,
    input  logic       above,
    output brti_rec_t  rec,
    output logic       better,
    output logic       suffix,
    output logic       at_pos,
    output logic       hit,
    output brti_rec_t  rd_rec
);

    brti_rec_t rec_reg;
    brti_rec_t rec_next;
    logic      better_reg;
    logic      better_next;
    logic      held;
    logic      shift_ok;
    logic      below_top;

    // slot holds a live record
    assign held = CW'(INDEX) < count;

    // rank against the probe item
    assign better_next = held && held_better(rec_reg.keys, probe, ctl.key_use, ctl.low_best);

    always_ff @(posedge clk)
    begin
        if (ctl.compare)
            better_reg <= better_next;
    end

    // some slot at or after this one ranks better
    assign suffix    = better_reg | above;
    // new item lands here: previous slot better, none after
    assign at_pos    = prev_better & ~suffix;
    // insert point lies before this slot
    assign shift_ok  = ~(prev_better | suffix);
    assign below_top = CW'(INDEX) < top;

    // record update on insert
    always_comb
    begin
        rec_next = rec_reg;
        if (ctl.insert)
        begin
            if (at_pos)
                rec_next = fresh;
            else if (shift_ok && below_top)
                rec_next = prev_rec;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    // read select, masked so the top can or the slots together
    assign hit    = (INDEX == int'(read_index)) && held;
    assign rd_rec = hit ? rec_reg : '0;

    assign rec    = rec_reg;
    assign better = better_reg;

endmodule

FILE: hw/rtl/bounded_ranked_table_insert_core.sv
// Top level of the bounded ranked table: handshakes, configuration,
// result register and the row of brti_cell slots. Depends on brti_pkg, brti_cell.
`timescale 1ns / 1ps
//
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  command  | cmd_valid, cmd_stall, cmd_item   | in
//  result   | res_valid, res_stall, res_item   | out
//  config   | cfg_write, cfg_index, cfg_data   | in
//
//  When an item is accepted, every slot ranks its record against the item's
//  keys in parallel; when the item completes, the slots shift and the result
//  register loads. No new item is taken while one is in flight.
//  A stalled result holds the item in flight and the table unchanged.
//  Reset empties the table and loads the configuration defaults.

module bounded_ranked_table_insert_core
    import brti_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  brti_in_t         cmd_item,
    output logic             res_valid,
    input  logic             res_stall,
    output brti_out_t        res_item,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > 5) ? CW : 5;

    logic [4:0]    max_entries_reg;
    logic [2:0]    keys_in_use_reg;
    logic [3:0]    low_mask_reg;
    logic          busy_reg;
    logic          busy_next;
    brti_in_t      op_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          res_valid_reg;
    logic          res_valid_next;
    brti_out_t     res_reg;
    brti_out_t     res_next;

    logic          accept;
    logic          go;
    brti_ctl_t     ctl;
    brti_rec_t     fresh;
    logic [CW-1:0] lim;
    logic [CW-1:0] top;
    logic [CW-1:0] pos_enc;
    logic          found;
    logic          placed;
    logic [LW-1:0] count_ext;
    logic [LW-1:0] pos_ext;
    brti_rec_t     rd_any;
    logic          hit_any;

    brti_rec_t               rec_w    [CAPACITY];
    brti_rec_t               rd_w     [CAPACITY];
    logic [CAPACITY-1:0]     better_w;
    logic [CAPACITY-1:0]     at_pos_w;
    logic [CAPACITY-1:0]     hit_w;
    logic [CAPACITY:0]       suffix_w;

    // handshakes
    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = busy_reg;
    assign go        = busy_reg && (!res_valid_reg || !res_stall);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= MAX_ENTRIES_RST;
            keys_in_use_reg <= KEYS_IN_USE_RST;
            low_mask_reg    <= LOW_MASK_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MAX_ENTRIES: max_entries_reg <= cfg_data[4:0];
                CFG_KEYS_IN_USE: keys_in_use_reg <= cfg_data[2:0];
                CFG_LOW_MASK:    low_mask_reg    <= cfg_data[3:0];
                default:         ;
            endcase
        end
    end

    // broadcast control
    always_comb
    begin
        ctl.compare  = accept;
        ctl.insert   = go && (op_reg.command == CMD_INSERT) && placed;
        ctl.low_best = low_mask_reg;
        for (int i = 0; i < KEY_FIELDS; i++)
            ctl.key_use[i] = (3'(i) < keys_in_use_reg) && (i < NUM_KEYS);
    end

    assign fresh.keys = item_keys(op_reg);
    assign fresh.tag  = op_reg.tag;

    // row of slots
    assign suffix_w[CAPACITY] = 1'b0;

    for (genvar j = 0; j < CAPACITY; j++)
    begin : g_cell
        logic      prev_better;
        brti_rec_t prev_rec;

        if (j == 0)
        begin : g_head
            assign prev_better = 1'b1;
            assign prev_rec    = fresh;
        end
        else
        begin : g_body
            assign prev_better = better_w[j-1];
            assign prev_rec    = rec_w[j-1];
        end

        brti_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (j)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .count       (count_reg),
            .top         (top),
            .read_index  (op_reg.read_index),
            .probe       (item_keys(cmd_item)),
            .fresh       (fresh),
            .prev_rec    (prev_rec),
            .prev_better (prev_better),
            .above       (suffix_w[j+1]),
            .rec         (rec_w[j]),
            .better      (better_w[j]),
            .suffix      (suffix_w[j]),
            .at_pos      (at_pos_w[j]),
            .hit         (hit_w[j]),
            .rd_rec      (rd_w[j])
        );
    end

    // insert point from the one-hot slot marks
    always_comb
    begin
        pos_enc = '0;
        for (int j = 0; j < CAPACITY; j++)
        begin
            if (at_pos_w[j])
                pos_enc = pos_enc | CW'(j);
        end
    end

    assign found = |at_pos_w;

    // limit is the smaller of max_entries and the capacity
    assign lim    = (LW'(max_entries_reg) < LW'(CAPACITY)) ? CW'(max_entries_reg)
                                                           : CW'(CAPACITY);
    assign placed = found && (pos_enc < lim);

    // count after an insert: grow by one unless that passes the limit
    assign top = (({1'b0, count_reg} + 1'b1) > {1'b0, lim}) ? count_reg
                                                            : CW'(count_reg + 1'b1);

    // gather the read slot
    always_comb
    begin
        rd_any = '0;
        for (int j = 0; j < CAPACITY; j++)
            rd_any = rd_any | rd_w[j];
    end

    assign hit_any = |hit_w;

    // command decode and result
    always_comb
    begin
        count_next = count_reg;
        res_next   = '0;
        unique case (op_reg.command)
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            CMD_INSERT:
            begin
                if (placed)
                    count_next = top;
                res_next.placed = placed;
            end
            CMD_QUERY:
            begin
                res_next.placed = placed;
            end
            CMD_READ:
            begin
                res_next.entry_valid     = hit_any;
                res_next.entry_key_zero  = rd_any.keys[0];
                res_next.entry_key_one   = rd_any.keys[1];
                res_next.entry_key_two   = rd_any.keys[2];
                res_next.entry_key_three = rd_any.keys[3];
                res_next.entry_tag       = rd_any.tag;
            end
            default: ;
        endcase
        count_ext            = LW'(count_next);
        pos_ext              = LW'(pos_enc);
        res_next.entry_count = count_ext[4:0];
        if (res_next.placed)
            res_next.position = pos_ext[3:0];
    end

    // item flow
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (go)
            busy_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (go)
            res_valid_next = 1'b1;
        else if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            res_valid_reg <= res_valid_next;
            if (go)
                count_reg <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            op_reg <= cmd_item;
        if (go)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

`ifndef NO_ASSERTIONS
    // table never holds more than its capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("record count above capacity");

    // at most one slot claims the insert point
    a_pos_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> $onehot0(at_pos_w))
        else $error("more than one insert point");

    // table only changes when an item completes
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !go |=> $stable(count_reg))
        else $error("count changed without a completing item");

    // a new item is never taken while one is in flight
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !go) |=> !accept)
        else $error("second item accepted while busy");
`endif

endmodule

FILE: test/tb_top.sv
// Testbench for bounded_ranked_table_insert_core: directed and random command items,
// checked field by field against a ranked table predictor kept in the bench.
// Depends on brti_pkg and bounded_ranked_table_insert_core.
`timescale 1ns / 1ps

module tb_top;
    import brti_pkg::*;

    localparam logic [31:0] KMAX = 32'h7fff_ffff;
    localparam logic [31:0] KMIN = 32'h8000_0000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cmd_valid = 1'b0;
    logic             cmd_stall;
    brti_in_t         cmd_item  = '0;
    logic             res_valid;
    logic             res_stall = 1'b0;
    brti_out_t        res_item;
    logic             cfg_write = 1'b0;
    logic [1:0]       cfg_index = CFG_MAX_ENTRIES;
    logic [CFG_W-1:0] cfg_data  = '0;

    // predicted table contents and configuration
    brti_keys_t            table_keys [DEFAULT_CAPACITY];
    logic [TAG_W-1:0]      table_tags [DEFAULT_CAPACITY];
    int unsigned           table_count   = 0;
    int unsigned           limit_reg     = MAX_ENTRIES_RST;
    int unsigned           key_count_reg = KEYS_IN_USE_RST;
    logic [KEY_FIELDS-1:0] low_best_reg  = LOW_MASK_RST;

    brti_out_t pending_results [$];
    int        mismatches = 0;
    bit        hurry      = 1'b0;
    int        stall_left = 0;
    int        open_left  = 0;

    bounded_ranked_table_insert_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // held record ranks strictly better than the new keys
    function automatic bit held_outranks(int slot, brti_keys_t probe);
        int n;
        n = key_count_reg;
        if (n > NUM_KEYS)
            n = NUM_KEYS;
        if (n > KEY_FIELDS)
            n = KEY_FIELDS;
        for (int i = 0; i < n; i++)
        begin
            if (table_keys[slot][i] != probe[i])
            begin
                if (low_best_reg[i])
                    return $signed(table_keys[slot][i]) < $signed(probe[i]);
                return $signed(table_keys[slot][i]) > $signed(probe[i]);
            end
        end
        return 1'b0;
    endfunction

    // one past the last held record that ranks better, scanning from the bottom
    function automatic int unsigned rank_position(brti_keys_t probe);
        int unsigned i;
        i = (table_count > DEFAULT_CAPACITY) ? DEFAULT_CAPACITY : table_count;
        while (i > 0)
        begin
            if (held_outranks(i - 1, probe))
                return i;
            i--;
        end
        return 0;
    endfunction

    // result of one command item, updating the predicted table
    function automatic brti_out_t table_outcome(brti_in_t it);
        brti_out_t   r;
        brti_keys_t  probe;
        int unsigned lim;
        int unsigned pos;
        int unsigned top;
        r = '0;
        probe[0] = it.key_zero;
        probe[1] = it.key_one;
        probe[2] = it.key_two;
        probe[3] = it.key_three;
        case (it.command)
            CMD_CLEAR:
                table_count = 0;
            CMD_INSERT, CMD_QUERY:
            begin
                lim = (limit_reg < DEFAULT_CAPACITY) ? limit_reg : DEFAULT_CAPACITY;
                pos = rank_position(probe);
                if (pos < lim)
                begin
                    r.placed   = 1'b1;
                    r.position = pos[3:0];
                    if (it.command == CMD_INSERT)
                    begin
                        // grow by one, or drop the last record when over the limit
                        top = (table_count + 1 > lim) ? table_count : table_count + 1;
                        if (top > DEFAULT_CAPACITY)
                            top = DEFAULT_CAPACITY;
                        for (int j = int'(top) - 1; j > int'(pos); j--)
                        begin
                            table_keys[j] = table_keys[j - 1];
                            table_tags[j] = table_tags[j - 1];
                        end
                        table_keys[pos] = probe;
                        table_tags[pos] = it.tag;
                        table_count     = top;
                    end
                end
            end
            default:
            begin
                if (it.read_index < table_count)
                begin
                    r.entry_valid     = 1'b1;
                    r.entry_key_zero  = table_keys[it.read_index][0];
                    r.entry_key_one   = table_keys[it.read_index][1];
                    r.entry_key_two   = table_keys[it.read_index][2];
                    r.entry_key_three = table_keys[it.read_index][3];
                    r.entry_tag       = table_tags[it.read_index];
                end
            end
        endcase
        r.entry_count = table_count[4:0];
        return r;
    endfunction

    // idle length: mostly short, a few long, none while hurrying
    function automatic int idle_cycles();
        int r;
        if (hurry)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // keys bunched near zero for ties, plus extremes and full-range values
    function automatic logic [31:0] random_key();
        logic [31:0] k;
        case ($urandom_range(0, 9))
            0:       k = KMIN;
            1:       k = KMAX;
            2, 3:    k = $urandom;
            default: k = $urandom_range(0, 6) - 3;
        endcase
        return k;
    endfunction

    function automatic brti_in_t make_item(brti_cmd_t c, logic [31:0] k0, logic [31:0] k1,
                                           logic [31:0] k2, logic [31:0] k3,
                                           logic [15:0] t, logic [3:0] idx);
        brti_in_t it;
        it.command    = c;
        it.key_zero   = k0;
        it.key_one    = k1;
        it.key_two    = k2;
        it.key_three  = k3;
        it.tag        = t;
        it.read_index = idx;
        return it;
    endfunction

    // inserts dominate so the table fills; clears are rare
    function automatic brti_in_t random_item();
        brti_cmd_t c;
        int        r;
        r = $urandom_range(0, 99);
        c = brti_cmd_t'((r < 3) ? CMD_CLEAR : (r < 55) ? CMD_INSERT
                                             : (r < 72) ? CMD_QUERY : CMD_READ);
        return make_item(c, random_key(), random_key(), random_key(), random_key(),
                         16'($urandom), 4'($urandom));
    endfunction

    // one mismatch line, counted
    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    endtask

    task automatic compare_result(brti_out_t got, brti_out_t want);
        if (got.placed !== want.placed)
            report("placed", got.placed, want.placed);
        if (got.position !== want.position)
            report("position", got.position, want.position);
        if (got.entry_count !== want.entry_count)
            report("entry_count", got.entry_count, want.entry_count);
        if (got.entry_valid !== want.entry_valid)
            report("entry_valid", got.entry_valid, want.entry_valid);
        if (got.entry_key_zero !== want.entry_key_zero)
            report("entry_key_zero", got.entry_key_zero, want.entry_key_zero);
        if (got.entry_key_one !== want.entry_key_one)
            report("entry_key_one", got.entry_key_one, want.entry_key_one);
        if (got.entry_key_two !== want.entry_key_two)
            report("entry_key_two", got.entry_key_two, want.entry_key_two);
        if (got.entry_key_three !== want.entry_key_three)
            report("entry_key_three", got.entry_key_three, want.entry_key_three);
        if (got.entry_tag !== want.entry_tag)
            report("entry_tag", got.entry_tag, want.entry_tag);
    endtask

    // result side: check each accepted item against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
                report("result with nothing pending", '0, '0);
            else
                compare_result(res_item, pending_results.pop_front());
        end
    end

    // result side stall: open stretches followed by random stalls
    always @(posedge clk)
    begin
        if (open_left > 0)
        begin
            open_left--;
            res_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            res_stall <= 1'b1;
        end
        else
        begin
            open_left  = $urandom_range(0, 8);
            stall_left = idle_cycles();
            res_stall <= 1'b0;
        end
    end

    // send one command item, predict it on accept, then maybe idle
    task automatic issue(brti_in_t it);
        int gap;
        cmd_valid <= 1'b1;
        cmd_item  <= it;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        pending_results.insert(pending_results.size(), table_outcome(it));
        gap = idle_cycles();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and wait until every result is back, plus the pipeline depth
    task automatic settle();
        cmd_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write all three registers on consecutive edges; only called when idle
    task automatic configure_table(logic [4:0] entries, logic [2:0] keys, logic [3:0] mask);
        cfg_write <= 1'b1;
        cfg_index <= CFG_MAX_ENTRIES;
        cfg_data  <= CFG_W'(entries);
        @(posedge clk);
        cfg_index <= CFG_KEYS_IN_USE;
        cfg_data  <= CFG_W'(keys);
        @(posedge clk);
        cfg_index <= CFG_LOW_MASK;
        cfg_data  <= CFG_W'(mask);
        @(posedge clk);
        cfg_write     <= 1'b0;
        limit_reg     = entries;
        key_count_reg = keys;
        low_best_reg  = mask;
    endtask

    // default config: empty reads, extreme keys, ties going ahead, clear
    task automatic test_empty_and_ties();
        issue(make_item(CMD_READ, 0, 0, 0, 0, 0, 4'd0));
        issue(make_item(CMD_QUERY, 0, 0, 0, 0, 0, 4'd0));
        issue(make_item(CMD_INSERT, KMAX, 0, 0, 0, 16'hffff, 4'd0));
        issue(make_item(CMD_INSERT, KMIN, KMAX, KMAX, KMAX, 16'h0000, 4'd0));
        issue(make_item(CMD_INSERT, KMAX, 1, 2, 3, 16'h0001, 4'd0));
        issue(make_item(CMD_INSERT, 0, KMIN, KMIN, KMIN, 16'h0002, 4'd0));
        issue(make_item(CMD_READ, 0, 0, 0, 0, 0, 4'd0));
        issue(make_item(CMD_READ, 0, 0, 0, 0, 0, 4'd3));
        issue(make_item(CMD_READ, 0, 0, 0, 0, 0, 4'd4));
        issue(make_item(CMD_READ, 0, 0, 0, 0, 0, 4'd15));
        issue(make_item(CMD_CLEAR, KMAX, KMAX, KMAX, KMAX, 16'hffff, 4'd15));
        issue(make_item(CMD_READ, 0, 0, 0, 0, 0, 4'd0));
        issue(make_item(CMD_QUERY, KMIN, 0, 0, 0, 0, 4'd0));
        settle();
    endtask

    // zero limit places nothing; zero keys makes every record rank equal
    task automatic test_no_room_and_all_equal();
        configure_table(5'd0, 3'd7, 4'hf);
        issue(make_item(CMD_INSERT, KMAX, KMAX, KMAX, KMAX, 16'h1234, 4'd0));
        issue(make_item(CMD_QUERY, KMIN, KMIN, KMIN, KMIN, 16'h4321, 4'd0));
        settle();
        configure_table(5'd31, 3'd0, 4'h0);
        issue(make_item(CMD_INSERT, KMAX, KMAX, KMAX, KMAX, 16'h5a5a, 4'd0));
        issue(make_item(CMD_INSERT, KMIN, KMIN, KMIN, KMIN, 16'ha5a5, 4'd0));
        issue(make_item(CMD_READ, 0, 0, 0, 0, 0, 4'd1));
        settle();
    endtask

    // mixed key directions, then a limit lowered below the held count
    task automatic test_limit_below_count();
        configure_table(5'd2, 3'd4, 4'b1010);
        issue(make_item(CMD_INSERT, KMAX, KMAX, 0, 0, 16'h0f0f, 4'd0));
        issue(make_item(CMD_INSERT, KMAX, KMIN, 0, 0, 16'hf0f0, 4'd0));
        settle();
        configure_table(5'd1, 3'd4, 4'b1010);
        issue(make_item(CMD_INSERT, 0, 0, 0, KMIN, 16'h1111, 4'd0));
        issue(make_item(CMD_INSERT, KMAX, KMIN, 0, KMIN, 16'h2222, 4'd0));
        issue(make_item(CMD_READ, 0, 0, 0, 0, 0, 4'd1));
        issue(make_item(CMD_READ, 0, 0, 0, 0, 0, 4'd2));
        settle();
    endtask

    // phases of random items under fixed and random settings
    task automatic test_random_phases();
        logic [4:0] entries;
        logic [2:0] keys;
        logic [3:0] mask;
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: begin entries = 5'd16; keys = 3'd4; mask = 4'h0; end
                1: begin entries = 5'd1;  keys = 3'd1; mask = 4'h1; end
                2: begin entries = 5'd31; keys = 3'd4; mask = 4'hf; end
                3: begin entries = 5'd0;  keys = 3'd7; mask = 4'h5; end
                4: begin entries = 5'd16; keys = 3'd2; mask = 4'h6; end
                default:
                begin
                    entries = ($urandom_range(0, 3) == 0) ? 5'($urandom)
                                                          : 5'($urandom_range(2, 16));
                    keys    = 3'($urandom);
                    mask    = 4'($urandom);
                end
            endcase
            settle();
            configure_table(entries, keys, mask);
            hurry = (p % 3 == 1);
            for (int n = 0; n < 75; n++)
            begin
                issue(random_item());
                // occasional full drain in the middle of a phase
                if ($urandom_range(0, 39) == 0)
                    settle();
            end
        end
        hurry = 1'b0;
        settle();
    endtask

    // run limit
    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_and_ties();
        test_no_room_and_all_equal();
        test_limit_below_count();
        test_random_phases();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
